// ===== sv/pibox_pkg.sv =====
// Shared types, constants and CORDIC table for the point-in-box test.
package pibox_pkg;

  localparam int FracBitsDef     = 16;
  localparam int CordicStagesDef = 16;
  localparam int CordicFrac      = 30;
  localparam int AtanCount       = 24;
  localparam int CordicW         = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;
  localparam int QueueDepth      = 4;

  // Angle of stage i, in 2^-32 turn.
  function automatic logic signed [CordicW-1:0] atan_turn(input int idx);
    logic signed [CordicW-1:0] r;
    r = '0;
    case (idx)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Word handed from the front part to the back part.
  typedef struct packed {
    logic signed [31:0] px, py, pz, cx, cy, cz;
    logic [30:0] sx, sy, sz;
    logic [15:0] ax, ay, az;
  } item_t;

endpackage

// ===== sv/pibox_front.sv =====
// Front part: accepts items into a short queue, hands them to the back part.
module pibox_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pibox_pkg::item_t push_word,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output pibox_pkg::item_t pop_word
);
  localparam int AW = $clog2(pibox_pkg::QueueDepth);

  pibox_pkg::item_t mem [pibox_pkg::QueueDepth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full     = (count == (AW+1)'(pibox_pkg::QueueDepth));
  assign avail    = (count != '0);
  assign pop_word = mem[rd_ptr];

  // Store the word at the write pointer.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(pibox_pkg::QueueDepth)) else $error("count out of range");
endmodule

// ===== sv/pibox_cordic.sv =====
// Pipelined CORDIC sine/cosine with registered stages and side-band delay.
module pibox_cordic #(
  parameter int FRAC_BITS     = pibox_pkg::FracBitsDef,
  parameter int CORDIC_STAGES = pibox_pkg::CordicStagesDef,
  parameter int SIDE_W        = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [15:0]                 angle,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [SIDE_W-1:0]           side_out,
  output logic signed [FRAC_BITS+2:0] cos_o,
  output logic signed [FRAC_BITS+2:0] sin_o
);
  localparam int W   = pibox_pkg::CordicW;
  localparam int NS  = (CORDIC_STAGES < pibox_pkg::AtanCount) ?
                       CORDIC_STAGES : pibox_pkg::AtanCount;
  localparam int SH  = pibox_pkg::CordicFrac - FRAC_BITS;
  localparam int OW  = FRAC_BITS + 3;

  logic signed [W-1:0] xs [NS+1];
  logic signed [W-1:0] ys [NS+1];
  logic signed [W-1:0] zs [NS+1];
  logic [1:0]          qs [NS+1];
  logic                vs [NS+1];
  logic [SIDE_W-1:0]   ss [NS+1];

  logic [15:0] q_ang, resid;
  logic [1:0]  quad;

  // Reduce the angle to the nearest quadrant.
  always_comb begin
    q_ang = angle + 16'h2000;
    quad  = q_ang[15:14];
    resid = angle - {quad, 14'b0};
  end

  always_ff @(posedge clk) begin
    xs[0] <= pibox_pkg::CordicGain;
    ys[0] <= '0;
    zs[0] <= {{(W-32){resid[15]}}, resid, 16'b0};
    qs[0] <= quad;
    ss[0] <= side_in;
  end

  always_ff @(posedge clk) begin
    if (rst) vs[0] <= 1'b0;
    else vs[0] <= in_valid;
  end

  // Rotate one step per stage.
  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!zs[i][W-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - pibox_pkg::atan_turn(i);
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + pibox_pkg::atan_turn(i);
      end
      qs[i+1] <= qs[i];
      ss[i+1] <= ss[i];
    end
    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else vs[i+1] <= vs[i];
    end
  end

  logic signed [W-1:0] ux, uy, rx, ry;

  // Map the quadrant back and round to the matrix format.
  always_comb begin
    case (qs[NS])
      2'd0: begin ux = xs[NS];  uy = ys[NS];  end
      2'd1: begin ux = -ys[NS]; uy = xs[NS];  end
      2'd2: begin ux = -xs[NS]; uy = -ys[NS]; end
      default: begin ux = ys[NS]; uy = -xs[NS]; end
    endcase
    rx = (ux + (W'(1) <<< (SH-1))) >>> SH;
    ry = (uy + (W'(1) <<< (SH-1))) >>> SH;
  end

  always_ff @(posedge clk) begin
    cos_o    <= rx[OW-1:0];
    sin_o    <= ry[OW-1:0];
    side_out <= ss[NS];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vs[NS];
  end
endmodule

// ===== sv/pibox_back.sv =====
// Back part: sines/cosines, rotation matrix, vector rotation and bound test.
module pibox_back #(
  parameter int FRAC_BITS     = pibox_pkg::FracBitsDef,
  parameter int CORDIC_STAGES = pibox_pkg::CordicStagesDef
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  pibox_pkg::item_t word,
  input  logic [30:0]      tol,
  output logic             out_valid,
  output logic             hit
);
  localparam int CW  = FRAC_BITS + 3;   // sin/cos and matrix entry width
  localparam int PW  = 2 * CW + 2;      // entry product sum width
  localparam int VW  = CW + 32 + 3;     // vector product sum width
  localparam int IW  = $bits(pibox_pkg::item_t);
  localparam logic signed [PW-1:0] RndM = PW'(1) <<< (FRAC_BITS-1);
  localparam logic signed [VW-1:0] RndV = VW'(1) <<< (FRAC_BITS-1);

  logic signed [CW-1:0] cx, sx, cy, sy, cz, sz;
  logic vx, vy, vz;
  pibox_pkg::item_t w0;
  logic [IW-1:0] side_x, side_y, side_z;

  pibox_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(IW)) u_cx (
    .clk, .rst, .in_valid, .angle(word.ax), .side_in(word),
    .out_valid(vx), .side_out(side_x), .cos_o(cx), .sin_o(sx));
  pibox_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(IW)) u_cy (
    .clk, .rst, .in_valid, .angle(word.ay), .side_in(IW'(0)),
    .out_valid(vy), .side_out(side_y), .cos_o(cy), .sin_o(sy));
  pibox_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES), .SIDE_W(IW)) u_cz (
    .clk, .rst, .in_valid, .angle(word.az), .side_in(IW'(0)),
    .out_valid(vz), .side_out(side_z), .cos_o(cz), .sin_o(sz));

  assign w0 = pibox_pkg::item_t'(side_x ^ side_y ^ side_z);

  // Stage 1: T = Rz^T * Ry^T products.
  logic signed [PW-1:0] t_p [4];
  logic signed [CW-1:0] s1_cx, s1_sx, s1_sz, s1_cz;
  pibox_pkg::item_t w1;
  logic v1;
  always_ff @(posedge clk) begin
    t_p[0] <= PW'(cz) * PW'(cy);
    t_p[1] <= -(PW'(cz) * PW'(sy));
    t_p[2] <= -(PW'(sz) * PW'(cy));
    t_p[3] <= PW'(sz) * PW'(sy);
    s1_cx <= cx; s1_sx <= sx; s1_sz <= sz; s1_cz <= cz;
    w1 <= w0;
  end

  // Stage 2: round T entries.
  // T = [[t00,sz,t02],[t10,cz,t12],[sy,0,cy]]
  logic signed [CW-1:0] t00, t02, t10, t12, t01, t11, t20, t22;
  logic signed [CW-1:0] s2_cx, s2_sx;
  logic signed [CW-1:0] s1_sy, s1_cy;
  pibox_pkg::item_t w2;
  logic v2;
  always_ff @(posedge clk) begin
    s1_sy <= sy; s1_cy <= cy;
  end
  always_ff @(posedge clk) begin
    t00 <= CW'((t_p[0] + RndM) >>> FRAC_BITS);
    t10 <= CW'((t_p[2] + RndM) >>> FRAC_BITS);
    t02 <= CW'((t_p[1] + RndM) >>> FRAC_BITS);
    t12 <= CW'((t_p[3] + RndM) >>> FRAC_BITS);
    t01 <= s1_sz;
    t11 <= s1_cz;
    t20 <= s1_sy;
    t22 <= s1_cy;
    s2_cx <= s1_cx; s2_sx <= s1_sx;
    w2 <= w1;
  end

  // Stage 3: M = T * Rx^T products; Rx^T = [[1,0,0],[0,c,s],[0,-s,c]].
  logic signed [PW-1:0] m_p [3][3];
  pibox_pkg::item_t w3;
  logic v3;
  logic signed [CW-1:0] tr [3][3];
  always_comb begin
    tr[0][0] = t00; tr[0][1] = t01; tr[0][2] = t02;
    tr[1][0] = t10; tr[1][1] = t11; tr[1][2] = t12;
    tr[2][0] = t20; tr[2][1] = '0;  tr[2][2] = t22;
  end
  for (genvar r = 0; r < 3; r++) begin : g_m
    always_ff @(posedge clk) begin
      m_p[r][0] <= PW'(tr[r][0]) <<< FRAC_BITS;
      m_p[r][1] <= PW'(tr[r][1]) * PW'(s2_cx) - PW'(tr[r][2]) * PW'(s2_sx);
      m_p[r][2] <= PW'(tr[r][1]) * PW'(s2_sx) + PW'(tr[r][2]) * PW'(s2_cx);
    end
  end
  always_ff @(posedge clk) w3 <= w2;

  // Stage 4: round M entries, form P - C exactly as difference of sums later.
  logic signed [CW-1:0] m [3][3];
  pibox_pkg::item_t w4;
  logic v4;
  for (genvar r = 0; r < 3; r++) begin : g_mr
    for (genvar c = 0; c < 3; c++) begin : g_mc
      always_ff @(posedge clk) m[r][c] <= CW'((m_p[r][c] + RndM) >>> FRAC_BITS);
    end
  end
  always_ff @(posedge clk) w4 <= w3;

  // Stage 5: rotation products for point and center.
  logic signed [VW-1:0] pp [3][3];
  logic signed [VW-1:0] cp [3][3];
  logic signed [31:0] pv [3];
  logic signed [31:0] cv [3];
  logic [30:0] s5 [3];
  assign pv[0] = w4.px; assign pv[1] = w4.py; assign pv[2] = w4.pz;
  assign cv[0] = w4.cx; assign cv[1] = w4.cy; assign cv[2] = w4.cz;
  for (genvar r = 0; r < 3; r++) begin : g_vp
    for (genvar c = 0; c < 3; c++) begin : g_vc
      always_ff @(posedge clk) begin
        pp[r][c] <= VW'(m[r][c]) * VW'(pv[c]);
        cp[r][c] <= VW'(m[r][c]) * VW'(cv[c]);
      end
    end
  end
  always_ff @(posedge clk) begin
    s5[0] <= w4.sx; s5[1] <= w4.sy; s5[2] <= w4.sz;
  end

  // Stage 6: sum and round rotated vectors, take the difference.
  logic signed [VW-1:0] d [3];
  logic [30:0] s6 [3];
  for (genvar r = 0; r < 3; r++) begin : g_d
    always_ff @(posedge clk) begin
      d[r] <= ((pp[r][0] + pp[r][1] + pp[r][2] + RndV) >>> FRAC_BITS)
            - ((cp[r][0] + cp[r][1] + cp[r][2] + RndV) >>> FRAC_BITS);
      s6[r] <= s5[r];
    end
  end

  // Stage 7: inclusive bound test, both sides doubled.
  logic [2:0] ok;
  logic signed [VW+2:0] lo [3];
  logic signed [VW+2:0] hi [3];
  logic signed [VW+2:0] sz2 [3];
  logic signed [VW+2:0] tol_w;
  always_comb begin
    tol_w = (VW+3)'($signed({1'b0, tol}));
    for (int r = 0; r < 3; r++) begin
      sz2[r] = (VW+3)'($signed({1'b0, s6[r]}));
      lo[r]  = ((VW+3)'(d[r]) + tol_w) <<< 1;
      hi[r]  = ((VW+3)'(d[r]) - tol_w) <<< 1;
      ok[r]  = (lo[r] >= -sz2[r]) && (hi[r] <= sz2[r]);
    end
  end

  // Valid bits follow the datapath.
  logic v5, v6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= vx; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      out_valid <= v6;
    end
  end
  always_ff @(posedge clk) hit <= &ok;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst) vx == vy && vy == vz)
    else $error("CORDIC lanes out of step");
  a_valid_chain: assert property (@(posedge clk) disable iff (rst) v6 |=> out_valid)
    else $error("valid chain broken");
  a_known_result: assert property (@(posedge clk) disable iff (rst) out_valid |-> !$isunknown(hit))
    else $error("unknown result");
endmodule

// ===== sv/point_in_oriented_box_test.sv =====
// Top level of the point-in-oriented-box test.
//
// Channel   Direction  Handshake             Payload
// input     in         start / busy          point_*, center_*, size_*, angle_*
// result    out        done (one cycle)      inside_res
// config    in         tolerance_we          tolerance_wdata
//
// One item per cycle sustained. From the accepting edge to the edge that takes
// the result, an item passes the queue, the CORDIC input register, the CORDIC
// stages (at most 24), the CORDIC output register, four matrix stages, two
// vector stages and the registered bound test.
// busy rises only when the four-word queue is full; the back part always
// advances because the receiver cannot stall. Reset is synchronous and
// empties the queue and pipeline, tolerance returns to zero.
module point_in_oriented_box_test #(
  parameter int FRAC_BITS     = pibox_pkg::FracBitsDef,
  parameter int CORDIC_STAGES = pibox_pkg::CordicStagesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        size_x,
  input  logic [30:0]        size_y,
  input  logic [30:0]        size_z,
  input  logic [15:0]        angle_x,
  input  logic [15:0]        angle_y,
  input  logic [15:0]        angle_z,
  input  logic               tolerance_we,
  input  logic [30:0]        tolerance_wdata,
  output logic               done,
  output logic               inside_res
);
  pibox_pkg::item_t in_word, q_word;
  logic push, full, avail;
  logic [30:0] tolerance;

  assign in_word = '{px: point_x, py: point_y, pz: point_z,
                     cx: center_x, cy: center_y, cz: center_z,
                     sx: size_x, sy: size_y, sz: size_z,
                     ax: angle_x, ay: angle_y, az: angle_z};
  assign busy = full;
  assign push = start && !busy;

  // Hold the tolerance register.
  always_ff @(posedge clk) begin
    if (rst) tolerance <= '0;
    else if (tolerance_we) tolerance <= tolerance_wdata;
  end

  pibox_front u_front (
    .clk, .rst, .push, .push_word(in_word), .full,
    .pop(avail), .avail, .pop_word(q_word));

  pibox_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk, .rst, .in_valid(avail), .word(q_word), .tol(tolerance),
    .out_valid(done), .hit(inside_res));
endmodule
